[rtl/bounded_sorted_topk_list_core_macros.svh]
// Assertion helpers shared by the list core.
`ifndef BOUNDED_SORTED_TOPK_LIST_CORE_MACROS_SVH
`define BOUNDED_SORTED_TOPK_LIST_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checks on clk_i, disabled while rst_ni is low.
`define BSTK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bstk assertion failed");
// Same check with an explicit clock and active-low reset.
`define BSTK_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bstk assertion failed");
`else
`define BSTK_ASSERT(lbl, prop)
`define BSTK_ASSERT_CLK(lbl, clk, rst_n, prop)
`endif

`endif

[rtl/bstk_pkg.sv]
`timescale 1ns / 1ps

package bstk_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned ScoreW   = 16;
  localparam int unsigned TagW     = 32;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_APPEND   = 3'd1,
    OP_DEL_LAST = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_READ     = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] new_points;
    logic [31:0] new_tag;
    logic [7:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [8:0]  entry_count;
    logic        was_stored;
    logic [7:0]  stored_position;
    logic        read_valid;
    logic [15:0] read_points;
    logic [31:0] read_tag;
  } rsp_t;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [TagW-1:0]   tag;
  } entry_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic              insert_en;
    logic              append_en;
    logic              read_en;
    logic [ScoreW-1:0] points;
    logic [TagW-1:0]   tag;
    logic [CntW-1:0]   count;
    logic [IdxW-1:0]   read_idx;
  } cell_ctrl_t;

endpackage

[rtl/bstk_if.sv]
`timescale 1ns / 1ps

interface bstk_req_if;
  logic              valid;
  logic              ready;
  bstk_pkg::req_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bstk_rsp_if;
  logic              valid;
  logic              ready;
  bstk_pkg::rsp_t    data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/bstk_cell.sv]
`timescale 1ns / 1ps

module bstk_cell (
  input  logic                          clk_i,
  input  bstk_pkg::cell_ctrl_t          ctrl_i,
  input  logic [bstk_pkg::IdxW-1:0]     idx_i,
  input  bstk_pkg::entry_t              prev_entry_i,
  input  logic                          prev_ok_i,
  input  logic                          next_ok_i,
  output logic                          ok_o,
  output logic                          new_hit_o,
  output bstk_pkg::entry_t              entry_o,
  output bstk_pkg::entry_t              rd_entry_o
);

  bstk_pkg::entry_t entry_q, entry_d;
  bstk_pkg::entry_t new_entry;
  logic             in_list;
  logic             lower;

  assign new_entry.score = ctrl_i.points;
  assign new_entry.tag   = ctrl_i.tag;

  // Empty slots count as lower; ok means every slot from here to the tail is lower.
  assign in_list   = bstk_pkg::CntW'(idx_i) < ctrl_i.count;
  assign lower     = !in_list || (entry_q.score < ctrl_i.points);
  assign ok_o      = lower && next_ok_i;
  assign new_hit_o = ok_o && !prev_ok_i;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert_en) begin
      if (new_hit_o) begin
        entry_d = new_entry;
      end else if (prev_ok_i) begin
        entry_d = prev_entry_i;
      end
    end else if (ctrl_i.append_en && (bstk_pkg::CntW'(idx_i) == ctrl_i.count)) begin
      entry_d = new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o    = entry_q;
  assign rd_entry_o = (ctrl_i.read_en && (idx_i == ctrl_i.read_idx)) ? entry_q : '0;

endmodule

[rtl/bounded_sorted_topk_list_core.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake    Payload
// req_i    in   valid/ready  opcode, new_points, new_tag, read_index
// rsp_o    out  valid/ready  entry_count, was_stored, stored_position,
//                            read_valid, read_points, read_tag
//
// One request per cycle: a row of 256 cells compares and shifts in parallel, so
// every opcode, sorted insert included, completes in the cycle it is accepted.
// The result sits in an output register; a new request is taken while that
// register is empty or being drained in the same cycle.
// Reset clears the entry count and the output valid; cell contents are not reset.

`include "bounded_sorted_topk_list_core_macros.svh"

module bounded_sorted_topk_list_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  bstk_req_if.sink    req_i,
  bstk_rsp_if.source  rsp_o
);

  localparam int unsigned Cap  = bstk_pkg::Capacity;
  localparam int unsigned IdxW = bstk_pkg::IdxW;
  localparam int unsigned CntW = bstk_pkg::CntW;

  logic                 accept;
  bstk_pkg::op_e        op;
  bstk_pkg::cell_ctrl_t ctrl;

  logic [CntW-1:0]      count_q, count_d;
  logic                 rsp_valid_q, rsp_valid_d;
  bstk_pkg::rsp_t       rsp_q, rsp_d;

  logic [Cap-1:0]       ok;
  logic [Cap-1:0]       hit;
  bstk_pkg::entry_t     entry  [Cap];
  bstk_pkg::entry_t     rd_ent [Cap];

  logic [IdxW-1:0]      hit_pos;
  bstk_pkg::entry_t     rd_sel;
  logic                 full;

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign op          = bstk_pkg::op_e'(req_i.data.opcode);
  assign full        = count_q == CntW'(Cap);

  assign ctrl.insert_en = accept && (op == bstk_pkg::OP_INSERT);
  assign ctrl.append_en = accept && (op == bstk_pkg::OP_APPEND);
  assign ctrl.read_en   = op == bstk_pkg::OP_READ;
  assign ctrl.points    = req_i.data.new_points;
  assign ctrl.tag       = req_i.data.new_tag;
  assign ctrl.count     = count_q;
  assign ctrl.read_idx  = IdxW'(req_i.data.read_index);

  for (genvar i = 0; i < Cap; i++) begin : g_cell
    logic             prev_ok;
    logic             next_ok;
    bstk_pkg::entry_t prev_entry;

    if (i == 0) begin : g_head
      assign prev_ok    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_ok    = ok[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == Cap - 1) begin : g_tail
      assign next_ok = 1'b1;
    end else begin : g_mid
      assign next_ok = ok[i+1];
    end

    bstk_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .idx_i        (IdxW'(i)),
      .prev_entry_i (prev_entry),
      .prev_ok_i    (prev_ok),
      .next_ok_i    (next_ok),
      .ok_o         (ok[i]),
      .new_hit_o    (hit[i]),
      .entry_o      (entry[i]),
      .rd_entry_o   (rd_ent[i])
    );
  end

  // At most one cell hits or matches the read index, so OR-ing gives the select.
  always_comb begin
    hit_pos = '0;
    rd_sel  = '0;
    for (int i = 0; i < Cap; i++) begin
      if (hit[i]) begin
        hit_pos = hit_pos | IdxW'(i);
      end
      rd_sel = rd_sel | rd_ent[i];
    end
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    unique case (op)
      bstk_pkg::OP_INSERT: begin
        if (ok[Cap-1]) begin
          rsp_d.was_stored      = 1'b1;
          rsp_d.stored_position = 8'(hit_pos);
          if (!full) begin
            count_d = count_q + CntW'(1);
          end
        end
      end
      bstk_pkg::OP_APPEND: begin
        if (!full) begin
          rsp_d.was_stored      = 1'b1;
          rsp_d.stored_position = 8'(count_q[IdxW-1:0]);
          count_d               = count_q + CntW'(1);
        end
      end
      bstk_pkg::OP_DEL_LAST: begin
        if (count_q != '0) begin
          count_d = count_q - CntW'(1);
        end
      end
      bstk_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      bstk_pkg::OP_READ: begin
        if (CntW'(req_i.data.read_index) < count_q) begin
          rsp_d.read_valid  = 1'b1;
          rsp_d.read_points = 16'(rd_sel.score);
          rsp_d.read_tag    = 32'(rd_sel.tag);
        end
      end
      default: begin
      end
    endcase
    rsp_d.entry_count = 9'(count_d);
  end

  assign rsp_valid_d = accept || (rsp_valid_q && !rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  `BSTK_ASSERT(a_count_bound, count_q <= CntW'(Cap))
  `BSTK_ASSERT(a_single_hit, $onehot0(hit))
  `BSTK_ASSERT(a_insert_grows,
      (ctrl.insert_en && ok[Cap-1] && !full) |=> (count_q == $past(count_q) + CntW'(1)))
  `BSTK_ASSERT(a_pos_in_list,
      (rsp_valid_q && rsp_q.was_stored) |->
      ({1'b0, rsp_q.stored_position} < rsp_q.entry_count))
  `BSTK_ASSERT_CLK(a_rsp_after_accept, clk_i, rst_ni, accept |=> rsp_valid_q)

endmodule
